// File: rtl/bup_pkg.sv
// shared types and constants of the bilinear rgb upscaler
package bup_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int ACC_W      = 10;
  localparam int POS_W      = 10;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [CH_W-1:0]      CH_MAX    = 8'd255;
  localparam logic [CFG_W-1:0]     DIM_RESET = 8'd128;
  localparam logic                 ACT_STORE   = 1'b0;
  localparam logic                 ACT_REQUEST = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADDR,
    S_READ,
    S_WAIT,
    S_EMIT
  } bup_state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } lane_ctl_t;

endpackage

// File: rtl/bilinear_upscale_rgb_unit.sv
// top level of the bilinear rgb upscaler: frame memory, sequencer, lanes and merge
//
// usage: the slave stream carries store and request items, tuser = 1 marks a request.
// a store inside the source frame writes one pixel into the on-chip frame; no
// store gives a result. a store is accepted, then written. a request gives exactly
// one result item on the master stream: interpolated red, green, blue and an
// out-of-range flag in tuser. a request off the output image answers zeros with
// the flag set, through the check and emit states. an in-range request runs
// divide, address, four sequential frame reads through the single read port of
// the one-port frame memory and the three-stage channel lanes, and the next item
// is accepted once the result is in the output register.
// the output register holds a result while the receiver stalls; the next item is
// still accepted then, and the sequencer waits only when a second result is ready.
// reset sets both source dimensions to 128 and empties the pipeline; the frame
// contents are undefined until written. configuration writes via cfg_we_i take
// effect at once and must only happen while the block is idle.
module bilinear_upscale_rgb_unit import bup_pkg::*; #(
  parameter int RATIO          = 7,
  parameter int MAX_SRC_WIDTH  = 128,
  parameter int MAX_SRC_HEIGHT = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y, in_red, in_green, in_blue, pad
  input  logic                   s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // out_red, out_green, out_blue
  output logic                   m_axis_tuser   // out_of_range
);

  localparam int XW     = $clog2(MAX_SRC_WIDTH);
  localparam int YW     = $clog2(MAX_SRC_HEIGHT);
  localparam int AW     = XW + YW;
  localparam int DEPTH  = 1 << AW;
  localparam int W_CAP  = (MAX_SRC_WIDTH > 255) ? 255 : MAX_SRC_WIDTH;
  localparam int H_CAP  = (MAX_SRC_HEIGHT > 255) ? 255 : MAX_SRC_HEIGHT;
  localparam int OLW    = $clog2(255 * RATIO + 1);
  localparam int CW     = (OLW > POS_W) ? OLW : POS_W;
  localparam int RS     = 16;
  localparam int RM     = (1 << RS) / RATIO;
  localparam int PMW    = POS_W + RS;
  localparam int FW     = $clog2(RATIO);
  localparam int WW     = $clog2(RATIO * RATIO + 1);
  localparam int EW     = POS_W + 1;

  bup_state_e state_q, state_d;

  logic [CFG_W-1:0]  src_w_q, src_h_q;
  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [CW-1:0]     out_w, out_h;

  logic              act_q;
  logic [POS_W-1:0]  px_q, py_q;
  logic [PIX_W-1:0]  rgb_q;
  logic              oor_q;
  logic [POS_W-1:0]  qxe_q, qye_q;
  logic [PMW-1:0]    prodx, prody;
  logic [POS_W-1:0]  rx, ry;
  logic [XW-1:0]     sx0_q, sx1_q;
  logic [YW-1:0]     sy0_q, sy1_q;
  logic [FW-1:0]     fx_q, fy_q;
  logic [EW-1:0]     sx0p1, sy0p1;
  logic [FW:0]       rfx, rfy;
  logic [WW-1:0]     wt_q [4];
  logic [1:0]        k_q;

  logic              req_oor, st_ok;
  logic              mem_we, rd_issue, emit_load, merge_free;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [PIX_W-1:0]  frame_q [DEPTH];
  logic [PIX_W-1:0]  rd_pix_q;
  logic [WW-1:0]     rd_wt_q;
  lane_ctl_t         rd_ctl_q;

  logic [NUM_CH-1:0]             lane_done;
  logic [NUM_CH-1:0][ACC_W-1:0]  lane_sum;

  // config registers and derived image limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_RESET;
      src_h_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (src_w_q > CFG_W'(W_CAP)) ? CFG_W'(W_CAP) : src_w_q;
  assign h_eff = (src_h_q > CFG_W'(H_CAP)) ? CFG_W'(H_CAP) : src_h_q;
  assign out_w = CW'(w_eff) * CW'(RATIO);
  assign out_h = CW'(h_eff) * CW'(RATIO);

  assign req_oor = (CW'(px_q) >= out_w) || (CW'(py_q) >= out_h);
  assign st_ok   = (POS_W'(w_eff) > px_q) && (POS_W'(h_eff) > py_q);

  // division by ratio: reciprocal estimate, then one correction step
  assign prodx = PMW'(px_q) * PMW'(RM);
  assign prody = PMW'(py_q) * PMW'(RM);
  assign rx    = px_q - POS_W'(qxe_q * POS_W'(RATIO));
  assign ry    = py_q - POS_W'(qye_q * POS_W'(RATIO));

  assign sx0p1 = EW'(sx0_q) + EW'(1);
  assign sy0p1 = EW'(sy0_q) + EW'(1);
  assign rfx   = (FW+1)'(RATIO) - (FW+1)'(fx_q);
  assign rfy   = (FW+1)'(RATIO) - (FW+1)'(fy_q);

  assign wr_addr = {py_q[YW-1:0], px_q[XW-1:0]};
  assign rd_addr = {k_q[1] ? sy1_q : sy0_q, k_q[0] ? sx1_q : sx0_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_CHECK;
      S_CHECK: begin
        if (act_q == ACT_STORE) begin
          state_d = S_IDLE;
        end else if (req_oor) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:   state_d = S_ADDR;
      S_ADDR:  state_d = S_READ;
      S_READ:  if (k_q == 2'd3) state_d = S_WAIT;
      S_WAIT:  if (&lane_done) state_d = S_EMIT;
      S_EMIT:  if (merge_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    rd_issue      = 1'b0;
    emit_load     = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_CHECK: mem_we = (act_q == ACT_STORE) && st_ok;
      S_READ:  rd_issue = 1'b1;
      S_EMIT:  emit_load = merge_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      rd_ctl_q <= '0;
    end else begin
      state_q        <= state_d;
      rd_ctl_q.valid <= rd_issue;
      rd_ctl_q.first <= (k_q == 2'd0);
      rd_ctl_q.last  <= (k_q == 2'd3);
      if (state_q == S_ADDR) begin
        k_q <= '0;
      end else if (rd_issue) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q <= s_axis_tuser;
      px_q  <= s_axis_tdata[9:0];
      py_q  <= s_axis_tdata[19:10];
      rgb_q <= {s_axis_tdata[27:20], s_axis_tdata[35:28], s_axis_tdata[43:36]};
    end
    if (state_q == S_CHECK) begin
      oor_q <= req_oor;
      qxe_q <= prodx[PMW-1:RS];
      qye_q <= prody[PMW-1:RS];
    end
    if (state_q == S_DIV) begin
      if (rx >= POS_W'(RATIO)) begin
        sx0_q <= XW'(qxe_q + POS_W'(1));
        fx_q  <= FW'(rx - POS_W'(RATIO));
      end else begin
        sx0_q <= XW'(qxe_q);
        fx_q  <= FW'(rx);
      end
      if (ry >= POS_W'(RATIO)) begin
        sy0_q <= YW'(qye_q + POS_W'(1));
        fy_q  <= FW'(ry - POS_W'(RATIO));
      end else begin
        sy0_q <= YW'(qye_q);
        fy_q  <= FW'(ry);
      end
    end
    if (state_q == S_ADDR) begin
      sx1_q   <= (sx0p1 < EW'(w_eff)) ? XW'(sx0p1) : XW'(w_eff - CFG_W'(1));
      sy1_q   <= (sy0p1 < EW'(h_eff)) ? YW'(sy0p1) : YW'(h_eff - CFG_W'(1));
      wt_q[0] <= WW'(rfx) * WW'(rfy);
      wt_q[1] <= WW'(fx_q) * WW'(rfy);
      wt_q[2] <= WW'(rfx) * WW'(fy_q);
      wt_q[3] <= WW'(fx_q) * WW'(fy_q);
    end
    rd_wt_q <= wt_q[k_q];
  end

  // frame memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_q[wr_addr] <= rgb_q;
    end
    rd_pix_q <= frame_q[rd_addr];
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    bup_lane #(
      .RATIO (RATIO)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (rd_ctl_q),
      .pix_i  (rd_pix_q[PIX_W-1-CH_W*c -: CH_W]),
      .wt_i   (rd_wt_q),
      .sum_o  (lane_sum[c]),
      .done_o (lane_done[c])
    );
  end

  bup_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit_load),
    .oor_i         (oor_q),
    .sums_i        (lane_sum),
    .free_o        (merge_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (state_q == S_WAIT))
    else $error("lane finished outside the wait state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded over a stalled result");
`endif

endmodule

// File: rtl/bup_lane.sv
// one color channel lane: weighted term, division by ratio squared, accumulation
module bup_lane import bup_pkg::*; #(
  parameter int RATIO = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lane_ctl_t                            ctl_i,
  input  logic [CH_W-1:0]                      pix_i,
  input  logic [$clog2(RATIO*RATIO+1)-1:0]     wt_i,
  output logic [ACC_W-1:0]                     sum_o,
  output logic                                 done_o
);

  localparam int DEN = RATIO * RATIO;
  localparam int WW  = $clog2(DEN + 1);
  localparam int PW  = CH_W + WW;
  localparam int DS  = 16;
  localparam int DM  = (1 << DS) / DEN;
  localparam int MW  = PW + DS;

  lane_ctl_t         ctl1_q, ctl2_q;
  logic              done_q;
  logic [PW-1:0]     prod_q, prod2_q, qe_q;
  logic [MW-1:0]     recip_mul;
  logic [PW-1:0]     rem;
  logic [PW-1:0]     term;
  logic [ACC_W-1:0]  acc_q;

  assign recip_mul = MW'(prod_q) * MW'(DM);
  assign rem       = prod2_q - qe_q * PW'(DEN);
  assign term      = (rem >= PW'(DEN)) ? qe_q + PW'(1) : qe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid && ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PW'(pix_i) * PW'(wt_i);
    prod2_q <= prod_q;
    qe_q    <= recip_mul[MW-1:DS];
    if (ctl2_q.valid) begin
      if (ctl2_q.first) begin
        acc_q <= ACC_W'(term);
      end else begin
        acc_q <= acc_q + ACC_W'(term);
      end
    end
  end

  assign sum_o  = acc_q;
  assign done_o = done_q;

endmodule

// File: rtl/bup_merge.sv
// merges the channel lanes: clamp, pack and hold the result item for the receiver
module bup_merge import bup_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic                              oor_i,
  input  logic [NUM_CH-1:0][ACC_W-1:0]      sums_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_DATA_W-1:0]             m_axis_tdata,  // out_red, out_green, out_blue
  output logic                              m_axis_tuser   // out_of_range
);

  logic                         valid_q;
  logic [NUM_CH-1:0][CH_W-1:0]  chan;
  logic [NUM_CH-1:0][CH_W-1:0]  chan_q;
  logic                         oor_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (oor_i) begin
        chan[c] = '0;
      end else if (sums_i[c] > ACC_W'(CH_MAX)) begin
        chan[c] = CH_MAX;
      end else begin
        chan[c] = sums_i[c][CH_W-1:0];
      end
    end
  end

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chan_q <= chan;
      oor_q  <= oor_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = chan_q;
  assign m_axis_tuser  = oor_q;

endmodule

// File: dv/bilinear_upscale_rgb_unit_test.sv
// self-checking stream test of the bilinear rgb upscaler against its own predictor
`timescale 1ns / 1ps

module bilinear_upscale_rgb_unit_test;
  import bup_pkg::*;

  localparam int RATIO          = 7;
  localparam int MAX_SRC_WIDTH  = 128;
  localparam int MAX_SRC_HEIGHT = 128;
  localparam int WEIGHT_DEN     = RATIO * RATIO;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_PICKS    = 40;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            out_of_range;
  } pixel_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_SRC_WIDTH;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // pos_x, pos_y, in_red, in_green, in_blue, pad
  logic                  s_axis_tuser  = ACT_STORE;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // out_red, out_green, out_blue
  logic                  m_axis_tuser;  // out_of_range

  logic [PIX_W-1:0] frame_copy [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
  bit               stored_px  [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
  logic [CFG_W-1:0] frame_width  = DIM_RESET;
  logic [CFG_W-1:0] frame_height = DIM_RESET;
  pixel_result_t    pending_pixels [$];
  pixel_result_t    got_px;
  pixel_result_t    want_px;
  int               mismatches = 0;
  int               stall_left = 0;
  bit               idle_on    = 1'b1;

  bilinear_upscale_rgb_unit #(
    .RATIO         (RATIO),
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned frame_cols();
    return (frame_width > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : frame_width;
  endfunction

  function automatic int unsigned frame_rows();
    return (frame_height > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : frame_height;
  endfunction

  // corner 0 top left, bit 0 selects the right column, bit 1 the lower row
  function automatic int unsigned corner_addr(int unsigned x, int unsigned y, int corner);
    int unsigned sx;
    int unsigned sy;
    sx = x / RATIO;
    sy = y / RATIO;
    if (corner[0] && sx + 1 < frame_cols()) sx++;
    if (corner[1] && sy + 1 < frame_rows()) sy++;
    return sy * MAX_SRC_WIDTH + sx;
  endfunction

  function automatic pixel_result_t upscale_pixel(int unsigned x, int unsigned y);
    pixel_result_t    res;
    int unsigned      fx;
    int unsigned      fy;
    int unsigned      wt;
    int unsigned      sum [3];
    logic [PIX_W-1:0] px;
    int               corner;
    res = '0;
    if (x >= frame_cols() * RATIO || y >= frame_rows() * RATIO) begin
      res.out_of_range = 1'b1;
      return res;
    end
    fx = x % RATIO;
    fy = y % RATIO;
    sum = '{0, 0, 0};
    for (corner = 0; corner < 4; corner++) begin
      px = frame_copy[corner_addr(x, y, corner)];
      wt = (corner[0] ? fx : RATIO - fx) * (corner[1] ? fy : RATIO - fy);
      sum[0] += px[23:16] * wt / WEIGHT_DEN;
      sum[1] += px[15:8] * wt / WEIGHT_DEN;
      sum[2] += px[7:0] * wt / WEIGHT_DEN;
    end
    res.red   = (sum[0] > CH_MAX) ? CH_MAX : CH_W'(sum[0]);
    res.green = (sum[1] > CH_MAX) ? CH_MAX : CH_W'(sum[1]);
    res.blue  = (sum[2] > CH_MAX) ? CH_MAX : CH_W'(sum[2]);
    return res;
  endfunction

  task automatic send_item(input logic act, input int unsigned x, input int unsigned y,
                           input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                           input logic [CH_W-1:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= IN_DATA_W'({b, g, r, POS_W'(y), POS_W'(x)});
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_STORE) begin
      if (x < frame_cols() && y < frame_rows()) begin
        frame_copy[y * MAX_SRC_WIDTH + x] = {r, g, b};
        stored_px[y * MAX_SRC_WIDTH + x]  = 1'b1;
      end
    end else begin
      pending_pixels.push_back(upscale_pixel(x, y));
    end
  endtask

  // writes any missing neighbor first so no unwritten pixel is ever read
  task automatic request_at(input int unsigned x, input int unsigned y);
    int unsigned addr;
    int          corner;
    if (x < frame_cols() * RATIO && y < frame_rows() * RATIO) begin
      for (corner = 0; corner < 4; corner++) begin
        addr = corner_addr(x, y, corner);
        if (!stored_px[addr])
          send_item(ACT_STORE, addr % MAX_SRC_WIDTH, addr / MAX_SRC_WIDTH,
                    CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      end
    end
    send_item(ACT_REQUEST, x, y, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SRC_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    frame_width = w;
    cfg_idx_i  <= REG_SRC_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    frame_height = h;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input int n, input bit with_idle);
    int unsigned cols;
    int unsigned rows;
    int unsigned pick;
    settle();
    set_dims(w, h);
    idle_on = with_idle;
    repeat (n) begin
      cols = frame_cols();
      rows = frame_rows();
      pick = $urandom_range(0, 99);
      if (pick < 55 && cols != 0 && rows != 0)
        request_at($urandom_range(0, cols * RATIO - 1), $urandom_range(0, rows * RATIO - 1));
      else if (pick < 72) begin
        if ($urandom_range(0, 1))
          request_at($urandom_range(cols * RATIO, POS_MAX), $urandom_range(0, POS_MAX));
        else
          request_at($urandom_range(0, POS_MAX), $urandom_range(rows * RATIO, POS_MAX));
      end else if (pick < 90 && cols != 0 && rows != 0)
        send_item(ACT_STORE, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      else if ($urandom_range(0, 1))
        send_item(ACT_STORE, $urandom_range(cols, POS_MAX), $urandom_range(0, POS_MAX),
                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      else
        send_item(ACT_STORE, $urandom_range(0, POS_MAX), $urandom_range(rows, POS_MAX),
                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    end
  endtask

  // corners, edge clamping and off-image requests at the reset geometry
  task automatic test_reset_geometry();
    send_item(ACT_STORE, 0, 0, 8'hff, 8'hff, 8'hff);
    send_item(ACT_STORE, 1, 0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_STORE, 0, 1, 8'hff, 8'h00, 8'h80);
    send_item(ACT_STORE, 1, 1, 8'h01, 8'h02, 8'h03);
    send_item(ACT_STORE, 127, 127, 8'hff, 8'hff, 8'hff);
    send_item(ACT_STORE, 126, 127, 8'h00, 8'hff, 8'h00);
    send_item(ACT_STORE, 127, 126, 8'h80, 8'h40, 8'h20);
    send_item(ACT_STORE, 126, 126, 8'hff, 8'h00, 8'hff);
    send_item(ACT_STORE, 128, 0, 8'hff, 8'hff, 8'hff);
    send_item(ACT_STORE, 0, 128, 8'hff, 8'hff, 8'hff);
    send_item(ACT_STORE, POS_MAX, POS_MAX, 8'hff, 8'hff, 8'hff);
    request_at(0, 0);
    request_at(6, 6);
    request_at(3, 4);
    request_at(895, 895);
    request_at(889, 882);
    request_at(882, 889);
    request_at(896, 0);
    request_at(0, 896);
    request_at(POS_MAX, POS_MAX);
  endtask

  // empty, single pixel, tiny and oversized frames, with and without idling
  task automatic test_geometry_sweep();
    logic [CFG_W-1:0] widths  [11] = '{2, 1, 0, 9, 255, 129, 3, 128, 16, 200, 5};
    logic [CFG_W-1:0] heights [11] = '{2, 1, 5, 0, 255, 2, 128, 3, 16, 7, 1};
    int               p;
    for (p = 0; p < 11; p++)
      run_random_phase(widths[p], heights[p], PHASE_PICKS, (p % 3) != 2);
  endtask

  task automatic test_full_rate();
    run_random_phase(8'd128, 8'd128, PHASE_PICKS, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_px.red          = m_axis_tdata[7:0];
      got_px.green        = m_axis_tdata[15:8];
      got_px.blue         = m_axis_tdata[23:16];
      got_px.out_of_range = m_axis_tuser;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with nothing pending: r=%0d g=%0d b=%0d oor=%0b",
                   $time, got_px.red, got_px.green, got_px.blue, got_px.out_of_range);
      end else begin
        want_px = pending_pixels.pop_front();
        if (got_px.red != want_px.red || got_px.green != want_px.green ||
            got_px.blue != want_px.blue || got_px.out_of_range != want_px.out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d oor=%0b,",
                     $time, want_px.red, want_px.green, want_px.blue, want_px.out_of_range,
                     " got r=%0d g=%0d b=%0d oor=%0b",
                     got_px.red, got_px.green, got_px.blue, got_px.out_of_range);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_geometry_sweep();
    test_full_rate();
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
